FILE: hdl/jsu_pkg.sv
package jsu_pkg;

    // Error codes carried in the status field of the final result.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_BADHEX  = 3'd3;
    localparam logic [2:0] ST_BADPAIR = 3'd4;

    // Characters that the decoder looks for.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        PH_PLAIN   = 7'b0000001,
        PH_ESC     = 7'b0000010,
        PH_HEX1    = 7'b0000100,
        PH_WANT_BS = 7'b0001000,
        PH_WANT_U  = 7'b0010000,
        PH_HEX2    = 7'b0100000,
        PH_PEND    = 7'b1000000
    } phase_t;

    // Up to four output bytes, first byte in entry 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
    } utf8_t;

    // One unit of work for the back end: the bytes one input byte produced.
    typedef struct packed {
        utf8_t      seq;
        logic       fin;
        logic [2:0] status;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } qhead_t;

    // Bit 4 is the valid flag, bits 3:0 the digit value.
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] r;
        begin
            r = '0;
            if (c inside {[8'h30:8'h39]}) begin
                r = {1'b1, c[3:0]};
            end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

    function automatic utf8_t utf8_encode(logic [20:0] cp);
        utf8_t r;
        begin
            r = '0;
            if (cp <= 21'h7F) begin
                r.bytes[0] = cp[7:0];
                r.nbytes = 3'd1;
            end else if (cp <= 21'h7FF) begin
                r.bytes[0] = {3'b110, cp[10:6]};
                r.bytes[1] = {2'b10, cp[5:0]};
                r.nbytes = 3'd2;
            end else if (cp <= 21'hFFFF) begin
                r.bytes[0] = {4'b1110, cp[15:12]};
                r.bytes[1] = {2'b10, cp[11:6]};
                r.bytes[2] = {2'b10, cp[5:0]};
                r.nbytes = 3'd3;
            end else begin
                r.bytes[0] = {5'b11110, cp[20:18]};
                r.bytes[1] = {2'b10, cp[17:12]};
                r.bytes[2] = {2'b10, cp[11:6]};
                r.bytes[3] = {2'b10, cp[5:0]};
                r.nbytes = 3'd4;
            end
            return r;
        end
    endfunction

endpackage

FILE: hdl/jsu_front.sv
module jsu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            is_final,
    output logic            push,
    output jsu_pkg::job_t   job
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic [2:0]  err_reg, err_next;
    logic        stop_reg, stop_next;

    jsu_pkg::utf8_t seq;
    logic [4:0]     hx;
    logic [15:0]    acc_sh;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        err_next   = err_reg;
        stop_next  = stop_reg;
        seq        = '0;
        hx         = jsu_pkg::hex_decode(in_byte);
        acc_sh     = {acc_reg[11:0], hx[3:0]};

        if (!stop_reg) begin
            case (phase_reg)
                jsu_pkg::PH_ESC: begin
                    phase_next = jsu_pkg::PH_PLAIN;
                    seq.nbytes = 3'd1;
                    case (in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSL: begin
                            seq.bytes[0] = in_byte;
                        end
                        jsu_pkg::CH_B: seq.bytes[0] = 8'h08;
                        jsu_pkg::CH_F: seq.bytes[0] = 8'h0C;
                        jsu_pkg::CH_N: seq.bytes[0] = 8'h0A;
                        jsu_pkg::CH_R: seq.bytes[0] = 8'h0D;
                        jsu_pkg::CH_T: seq.bytes[0] = 8'h09;
                        jsu_pkg::CH_U: begin
                            seq.nbytes = 3'd0;
                            phase_next = jsu_pkg::PH_HEX1;
                            cnt_next = 2'd0;
                            acc_next = '0;
                            if (is_final) begin
                                err_next = jsu_pkg::ST_BADHEX;
                                stop_next = 1'b1;
                            end
                        end
                        default: begin
                            seq.nbytes = 3'd0;
                            err_next = jsu_pkg::ST_UNKNOWN;
                            stop_next = 1'b1;
                        end
                    endcase
                end
                jsu_pkg::PH_HEX1: begin
                    if (!hx[4]) begin
                        err_next = jsu_pkg::ST_BADHEX;
                        stop_next = 1'b1;
                    end else begin
                        acc_next = acc_sh;
                        if (cnt_reg == 2'd3) begin
                            cnt_next = 2'd0;
                            if (acc_sh >= jsu_pkg::SURR_HI_MIN &&
                                acc_sh <= jsu_pkg::SURR_HI_MAX) begin
                                hs_next = acc_sh[9:0];
                                phase_next = jsu_pkg::PH_WANT_BS;
                                if (is_final) begin
                                    err_next = jsu_pkg::ST_BADPAIR;
                                    stop_next = 1'b1;
                                end
                            end else begin
                                seq = jsu_pkg::utf8_encode({5'd0, acc_sh});
                                phase_next = jsu_pkg::PH_PLAIN;
                            end
                        end else begin
                            cnt_next = cnt_reg + 2'd1;
                            if (is_final) begin
                                err_next = jsu_pkg::ST_BADHEX;
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
                jsu_pkg::PH_WANT_BS: begin
                    if (in_byte != jsu_pkg::CH_BSL || is_final) begin
                        err_next = jsu_pkg::ST_BADPAIR;
                        stop_next = 1'b1;
                    end else begin
                        phase_next = jsu_pkg::PH_WANT_U;
                    end
                end
                jsu_pkg::PH_WANT_U: begin
                    if (in_byte != jsu_pkg::CH_U || is_final) begin
                        err_next = jsu_pkg::ST_BADPAIR;
                        stop_next = 1'b1;
                    end else begin
                        phase_next = jsu_pkg::PH_HEX2;
                        cnt_next = 2'd0;
                        acc_next = '0;
                    end
                end
                jsu_pkg::PH_HEX2: begin
                    if (!hx[4]) begin
                        if (cnt_reg == 2'd3) begin
                            err_next = jsu_pkg::ST_BADHEX;
                            stop_next = 1'b1;
                        end else if (is_final) begin
                            err_next = jsu_pkg::ST_BADPAIR;
                            stop_next = 1'b1;
                        end else begin
                            // Count down the bytes still owed to the second group.
                            cnt_next = 2'd3 - cnt_reg;
                            phase_next = jsu_pkg::PH_PEND;
                        end
                    end else begin
                        acc_next = acc_sh;
                        if (cnt_reg == 2'd3) begin
                            cnt_next = 2'd0;
                            seq = jsu_pkg::utf8_encode(jsu_pkg::SUPP_BASE +
                                                       {1'b0, hs_reg, acc_sh[9:0]});
                            phase_next = jsu_pkg::PH_PLAIN;
                        end else begin
                            cnt_next = cnt_reg + 2'd1;
                            if (is_final) begin
                                err_next = jsu_pkg::ST_BADPAIR;
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
                jsu_pkg::PH_PEND: begin
                    cnt_next = cnt_reg - 2'd1;
                    if (cnt_next == 2'd0) begin
                        err_next = jsu_pkg::ST_BADHEX;
                        stop_next = 1'b1;
                    end else if (is_final) begin
                        err_next = jsu_pkg::ST_BADPAIR;
                        stop_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = jsu_pkg::PH_PLAIN;
                    if (in_byte == jsu_pkg::CH_QUOTE) begin
                        stop_next = 1'b1;
                    end else if (in_byte == jsu_pkg::CH_BSL) begin
                        phase_next = jsu_pkg::PH_ESC;
                        if (is_final) begin
                            err_next = jsu_pkg::ST_EMPTY;
                            stop_next = 1'b1;
                        end
                    end else begin
                        seq.bytes[0] = in_byte;
                        seq.nbytes = 3'd1;
                    end
                end
            endcase
        end

        job.seq    = seq;
        job.fin    = is_final;
        job.status = err_next;
        push       = accept && (is_final || seq.nbytes != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= jsu_pkg::PH_PLAIN;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            hs_reg    <= '0;
            err_reg   <= jsu_pkg::ST_OK;
            stop_reg  <= 1'b0;
        end else if (accept) begin
            if (is_final) begin
                phase_reg <= jsu_pkg::PH_PLAIN;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                hs_reg    <= '0;
                err_reg   <= jsu_pkg::ST_OK;
                stop_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                hs_reg    <= hs_next;
                err_reg   <= err_next;
                stop_reg  <= stop_next;
            end
        end
    end

endmodule

FILE: hdl/jsu_queue.sv
module jsu_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jsu_pkg::job_t    push_job,
    input  logic             pop,
    output jsu_pkg::qhead_t  head,
    output logic             full
);

    jsu_pkg::job_t mem_reg [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [jsu_pkg::QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (jsu_pkg::QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (jsu_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + jsu_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + jsu_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/jsu_back.sv
module jsu_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  jsu_pkg::qhead_t  head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic [4:0]       m_tuser
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic [4:0] user_reg, user_next;
    logic [1:0] idx_reg, idx_next;
    logic       load, is_end, has_bytes;

    assign load      = !valid_reg || m_tready;
    assign has_bytes = (head.job.seq.nbytes != 3'd0);
    assign is_end    = !has_bytes || ({1'b0, idx_reg} + 3'd1 == head.job.seq.nbytes);
    assign pop       = load && head.valid && is_end;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                data_next = has_bytes ? head.job.seq.bytes[idx_reg] : 8'h00;
                last_next = is_end;
                user_next[0] = has_bytes;
                user_next[1] = head.job.fin && is_end;
                user_next[4:2] = (head.job.fin && is_end) ? head.job.status
                                                          : jsu_pkg::ST_OK;
                idx_next = is_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

FILE: hdl/json_string_unescape_utf8.sv
// Channel   Direction  Payload                                   End marker
// s_        in         tdata: raw string body byte               tlast: final byte
// m_        out        tdata: UTF-8 byte; tuser: flags, status   tlast: last of request
//
// The block takes one input request per cycle as long as its job queue has room.
// A decoded byte is written into the job queue and then into the output register; an
// input byte yields up to four result bytes, sent at one per cycle while m_tready is high.
// Reset is synchronous on aresetn low and returns the decoder to plain text with
// an empty queue. A stall on m_ holds the output register; the four-entry queue
// between decoder and output stage keeps s_tready high until it fills.
module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [4:0] m_tuser    // [0] byte_valid, [1] string_done, [4:2] status
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    jsu_pkg::job_t   job;
    jsu_pkg::qhead_t head;

    // The decoder runs on every accepted request; only the queue can hold it off.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_byte  (s_tdata),
        .is_final (s_tlast),
        .push     (push),
        .job      (job)
    );

    // Holds the decoded byte groups until the output stage drains them.
    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .full     (full)
    );

    // Splits each group into single-byte results behind the output register.
    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The end of a string always closes the run of its final input byte.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("string end not marked as last of its request");

    // A result without a data byte only appears as the end of a string.
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tuser[1])
        else $error("empty result before end of string");

    // Error codes are reported on the final result only.
    a_status_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4:2] != jsu_pkg::ST_OK) |-> m_tuser[1])
        else $error("status reported before end of string");

    // Nothing is queued while the queue is full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

endmodule
